// ===== rtl/bpad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpad_pkg: shared types and constants
// Sizes, command and register codes, sequencer states and the control
// group between the top level and the scaling datapath.
// ----------------------------------------------------------------------------
package bpad_pkg;

    // Converter geometry
    localparam int CHANNELS  = 16;
    localparam int WORD_BITS = 16;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);

    // Field widths
    localparam int CMD_W        = 2;
    localparam int CH_FIELD_W   = 4;
    localparam int CODE_W       = 12;
    localparam int GAIN_W       = 24;
    localparam int VOLTS_W      = 32;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 48;
    localparam int OUT_USER_W   = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Scaling arithmetic
    localparam int PROD_W   = 38;   // |gain| * |5*code - 20475| stays below 2^38
    localparam int QUOT_W   = 26;   // rounded quotient stays at or below 5 * 2^23
    localparam int MUL_W    = 26;   // operand width of the shared multiplier
    localparam int DIFF_W   = 15;
    localparam logic [DIFF_W-1:0] CODE_OFFSET = 15'd20475;  // 5 * 4095
    localparam logic [PROD_W-1:0] ROUND_HALF  = 38'd2047;
    localparam logic [12:0]       DIVISOR     = 13'd4095;
    // 4095 * INV_4095 == 1 modulo 2^26: exact division of a multiple of 4095
    localparam logic [MUL_W-1:0]  INV_4095    = 26'h2FFEFFF;

    // Reset values
    localparam logic [7:0]        HEADER_WORDS_RST = 8'd18;
    localparam logic [15:0]       POINTS_RST       = 16'd1024;
    localparam logic [GAIN_W-1:0] UNITY_GAIN       = 24'd65536;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GAIN  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS       = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_DIV,
        ST_LOAD
    } bpad_state_t;

    typedef struct packed {
        logic ld_prod;
        logic ld_rem;
        logic ld_quot;
    } bpad_ctl_t;

endpackage

// ===== rtl/bpad_volts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpad_volts: shared scaling datapath
// One 26x26 multiplier used twice per channel: first gain times code offset,
// then an exact division by 4095 through its modular inverse.
// ----------------------------------------------------------------------------
module bpad_volts
    import bpad_pkg::*;
(
    input  logic                      clk,
    input  bpad_ctl_t                 ctl,
    input  logic [CODE_W-1:0]         code,
    input  logic signed [GAIN_W-1:0]  gain,
    output logic [VOLTS_W-1:0]        volts
);

    logic [PROD_W-1:0] prod_reg;
    logic [MUL_W-1:0]  xr_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              neg_reg;

    logic [GAIN_W-1:0]   gain_mag;
    logic [DIFF_W-1:0]   diff_mag;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic [PROD_W-1:0]   x;
    logic [13:0]         digit_sum;
    logic [12:0]         fold;
    logic [12:0]         rem;

    // Magnitudes: 5*code never exceeds 20475, so the offset is never positive
    assign gain_mag = gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
    assign diff_mag = CODE_OFFSET - DIFF_W'(code) * DIFF_W'(5);

    assign mul_a = ctl.ld_prod ? MUL_W'(gain_mag) : xr_reg;
    assign mul_b = ctl.ld_prod ? MUL_W'(diff_mag) : INV_4095;
    assign mul_p = mul_a * mul_b;

    // Remainder modulo 4095 from the sum of base-4096 digits
    always_comb
    begin
        x         = prod_reg + ROUND_HALF;
        digit_sum = 14'(x[11:0]) + 14'(x[23:12]) + 14'(x[35:24]) + 14'(x[37:36]);
        fold      = 13'(digit_sum[11:0]) + 13'(digit_sum[13:12]);
        rem       = (fold >= DIVISOR) ? fold - DIVISOR : fold;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            prod_reg <= mul_p[PROD_W-1:0];
            // the offset is never positive: the product takes the opposite sign of the gain
            neg_reg  <= !gain[GAIN_W-1];
        end
        if (ctl.ld_rem)
        begin
            xr_reg <= x[MUL_W-1:0] - MUL_W'(rem[11:0]);
        end
        if (ctl.ld_quot)
        begin
            quot_reg <= mul_p[QUOT_W-1:0];
        end
    end

    // Quotient stays far below 2^31, so no saturation is reached
    assign volts = neg_reg ? VOLTS_W'(-VOLTS_W'(quot_reg)) : VOLTS_W'(quot_reg);

endmodule

// ===== rtl/bit_plane_adc_deinterleave_scale_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_plane_adc_deinterleave_scale_top: 16-channel bit-plane deinterleaver
// Collects bit-serial converter words into per-channel codes and emits one
// gain-scaled voltage per channel at the end of every measurement point.
// ----------------------------------------------------------------------------
// Usage: send a start request (tuser = 0) to open a frame; the block then
// drops header_words bus words and shifts bit m of every following data
// request (tuser = 1), MSB first, into channel m. Gain requests (tuser = 2)
// load one entry of the Q.16 gain table, unity after reset. Start, gain and
// header or non-final data requests are accepted while the sequencer is idle.
// The data request that completes a point starts the result sequence: each
// channel goes through the single shared multiplier twice (gain product, then
// exact division by 4095) in the multiply, reduce, divide and load states; the
// input stays not ready until the last channel is loaded, longer while the
// output is stalled. The result register decouples the sides: the last result
// of a point may wait while the next request is already accepted. The last
// channel of a point carries tlast; the last result of the frame also carries
// last_of_frame, after which data requests are ignored until the next start.
// ----------------------------------------------------------------------------
module bit_plane_adc_deinterleave_scale_top
    import bpad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // bus_word[15:0], gain_channel[19:16],
                                                   // gain_value[43:20], zero[47:44]
    input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd[1:0]
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // code[11:0], volts[43:12], zero[47:44]
    output logic [OUT_USER_W-1:0]  m_axis_tuser,   // channel[3:0], last_of_frame[4]
    output logic                   m_axis_tlast    // last_of_point
);

    bpad_state_t state_reg;
    bpad_state_t state_next;

    logic [7:0]        header_words_reg;
    logic [15:0]       points_reg;
    logic [7:0]        header_left_reg;
    logic [BIT_W-1:0]  bit_count_reg;
    logic [15:0]       point_count_reg;
    logic              frame_active_reg;
    logic              last_frame_reg;
    logic [CH_W-1:0]   ch_reg;

    logic [WORD_BITS-1:0]     channel_shift_reg [CHANNELS];
    logic signed [GAIN_W-1:0] gain_reg          [CHANNELS];

    logic                    out_valid_reg;
    logic [CH_FIELD_W-1:0]   out_ch_reg;
    logic [CODE_W-1:0]       out_code_reg;
    logic [VOLTS_W-1:0]      out_volts_reg;
    logic                    out_lop_reg;
    logic                    out_lof_reg;

    // Request fields
    logic [CMD_W-1:0]        cmd;
    logic [15:0]             bus_word;
    logic [CH_FIELD_W-1:0]   gain_channel;
    logic [GAIN_W-1:0]       gain_value;

    logic                    accept;
    logic                    is_data;
    logic                    bit_last;
    logic                    point_end;
    logic [15:0]             point_next;
    logic                    ch_last;
    logic                    load_out;
    logic                    seq_done;
    bpad_ctl_t               ctl;

    logic [WORD_BITS+11:0]   shift_ext;
    logic [CODE_W-1:0]       cur_code;
    logic [VOLTS_W-1:0]      cur_volts;

    assign cmd          = s_axis_tuser;
    assign bus_word     = s_axis_tdata[15:0];
    assign gain_channel = s_axis_tdata[19:16];
    assign gain_value   = s_axis_tdata[43:20];

    assign cfg_ready = 1'b1;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign is_data    = accept && (cmd == CMD_DATA) && frame_active_reg
                        && (header_left_reg == 8'd0);
    assign bit_last   = (bit_count_reg == BIT_W'(WORD_BITS - 1));
    assign point_end  = is_data && bit_last;
    assign point_next = point_count_reg + 16'd1;
    assign ch_last    = (ch_reg == CH_W'(CHANNELS - 1));

    // Code of the channel under the sequencer: (shift >> 2) & 0xfff
    assign shift_ext = {12'd0, channel_shift_reg[ch_reg]};
    assign cur_code  = shift_ext[13:2];

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (point_end)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_RED;
            ST_RED:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (load_out)
                begin
                    state_next = ch_last ? ST_IDLE : ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        ctl           = '0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MUL:  ctl.ld_prod   = 1'b1;
            ST_RED:  ctl.ld_rem    = 1'b1;
            ST_DIV:  ctl.ld_quot   = 1'b1;
            ST_LOAD: load_out      = !out_valid_reg || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign seq_done = load_out && ch_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers: index beyond the list is dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_words_reg <= HEADER_WORDS_RST;
            points_reg       <= POINTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEADER_WORDS: header_words_reg <= cfg_data[7:0];
                REG_POINTS:       points_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame control: header skip, bit and point counting
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg  <= '0;
            bit_count_reg    <= '0;
            point_count_reg  <= '0;
            frame_active_reg <= 1'b0;
            last_frame_reg   <= 1'b0;
            ch_reg           <= '0;
        end
        else
        begin
            if (accept && (cmd == CMD_START))
            begin
                frame_active_reg <= 1'b1;
                header_left_reg  <= header_words_reg;
                bit_count_reg    <= '0;
                point_count_reg  <= '0;
            end
            else if (accept && (cmd == CMD_DATA) && frame_active_reg
                     && (header_left_reg != 8'd0))
            begin
                header_left_reg <= header_left_reg - 8'd1;
            end
            else if (is_data)
            begin
                if (bit_last)
                begin
                    bit_count_reg <= '0;
                    // a zero limit lets the counter wrap: 65536 points
                    last_frame_reg  <= (point_next == points_reg);
                    point_count_reg <= (point_next == points_reg) ? 16'd0 : point_next;
                end
                else
                begin
                    bit_count_reg <= bit_count_reg + BIT_W'(1);
                end
            end

            if (load_out)
            begin
                ch_reg <= ch_last ? CH_W'(0) : ch_reg + CH_W'(1);
            end
            // close the frame once its last result is loaded into the result register
            if (seq_done && last_frame_reg)
            begin
                frame_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel shift registers and gain table
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < CHANNELS; m++)
            begin
                channel_shift_reg[m] <= '0;
                gain_reg[m]          <= UNITY_GAIN;
            end
        end
        else
        begin
            if ((accept && (cmd == CMD_START)) || seq_done)
            begin
                for (int m = 0; m < CHANNELS; m++)
                begin
                    channel_shift_reg[m] <= '0;
                end
            end
            else if (is_data)
            begin
                // shift MSB first; bus bits above the channel count are dropped
                for (int m = 0; m < CHANNELS; m++)
                begin
                    channel_shift_reg[m] <= {channel_shift_reg[m][WORD_BITS-2:0], bus_word[m]};
                end
            end

            if (accept && (cmd == CMD_GAIN) && (32'(gain_channel) < CHANNELS))
            begin
                gain_reg[gain_channel[CH_W-1:0]] <= gain_value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared scaling unit
    // ------------------------------------------------------------------
    bpad_volts u_volts
    (
        .clk   (clk),
        .ctl   (ctl),
        .code  (cur_code),
        .gain  (gain_reg[ch_reg]),
        .volts (cur_volts)
    );

    // ------------------------------------------------------------------
    // Result register: hold until taken, reload in the same cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch_reg    <= CH_FIELD_W'(ch_reg);
            out_code_reg  <= cur_code;
            out_volts_reg <= cur_volts;
            out_lop_reg   <= ch_last;
            out_lof_reg   <= ch_last && last_frame_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_volts_reg, out_code_reg};
    assign m_axis_tuser  = {out_lof_reg, out_ch_reg};
    assign m_axis_tlast  = out_lop_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_seq_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> frame_active_reg)
        else $error("result sequence running outside a frame");

    a_bits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (bit_count_reg == '0))
        else $error("bit counter not cleared during result sequence");

    a_frame_end_marks_point: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_lof_reg) |-> out_lop_reg)
        else $error("frame end without point end");

    a_point_end_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_ch_reg == CH_FIELD_W'(CHANNELS - 1)))
        else $error("point end on a channel other than the last");

    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        point_end |=> ((state_reg == ST_MUL) && (ch_reg == '0)))
        else $error("point end did not start the sequence at channel zero");

endmodule
